// ----- src/tmfr_pkg.sv -----
// ----------------------------------------------------------------------------
// tmfr_pkg
// Shared types and constants of the trimmed-mean force row scanner: sample
// width, channel count, row index width and the row tag that travels with a
// finished row through the pipeline.
// ----------------------------------------------------------------------------
package tmfr_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int CHANNELS    = 6;
  localparam int ROW_BITS    = 4;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [CHANNELS-1:0] sample_vec_t;
  typedef logic [ROW_BITS-1:0]    row_t;

  typedef struct packed {
    row_t row;
    logic done;
  } row_tag_t;

endpackage

// ----- src/tmfr_in_if.sv -----
// ----------------------------------------------------------------------------
// tmfr_in_if
// Conversion channel: one beat carries the restart flag and six samples.
// ----------------------------------------------------------------------------
interface tmfr_in_if;
  import tmfr_pkg::*;

  logic    valid;
  logic    ready;
  logic    restart;
  sample_t sample_ch0;
  sample_t sample_ch1;
  sample_t sample_ch2;
  sample_t sample_ch3;
  sample_t sample_ch4;
  sample_t sample_ch5;

  modport source (
    output valid, restart,
    output sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4, sample_ch5,
    input  ready
  );

  modport sink (
    input  valid, restart,
    input  sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4, sample_ch5,
    output ready
  );

endinterface

// ----- src/tmfr_out_if.sv -----
// ----------------------------------------------------------------------------
// tmfr_out_if
// Result channel: one beat carries a row index, the scan-done flag and the
// six trimmed means of that row.
// ----------------------------------------------------------------------------
interface tmfr_out_if;
  import tmfr_pkg::*;

  logic    valid;
  logic    ready;
  row_t    row_index;
  logic    scan_done;
  sample_t avg_ch0;
  sample_t avg_ch1;
  sample_t avg_ch2;
  sample_t avg_ch3;
  sample_t avg_ch4;
  sample_t avg_ch5;

  modport source (
    output valid, row_index, scan_done,
    output avg_ch0, avg_ch1, avg_ch2, avg_ch3, avg_ch4, avg_ch5,
    input  ready
  );

  modport sink (
    input  valid, row_index, scan_done,
    input  avg_ch0, avg_ch1, avg_ch2, avg_ch3, avg_ch4, avg_ch5,
    output ready
  );

endinterface

// ----- src/tmfr_accum.sv -----
// ----------------------------------------------------------------------------
// tmfr_accum
// Per-channel running sum, minimum and maximum with sample and row counters.
// On the last sample of a row, the final sums and extremes are captured in a
// row record register for the divider.
// ----------------------------------------------------------------------------
module tmfr_accum #(
  parameter int SAMPLES = 8,
  parameter int ROWS    = 10,
  parameter int SUM_W   = 15
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       in_restart,
  input  tmfr_pkg::sample_vec_t                      in_samples,
  output logic                                       rec_valid,
  input  logic                                       rec_ready,
  output tmfr_pkg::row_tag_t                         rec_tag,
  output logic [tmfr_pkg::CHANNELS-1:0][SUM_W-1:0]   rec_sum,
  output tmfr_pkg::sample_vec_t                      rec_min,
  output tmfr_pkg::sample_vec_t                      rec_max
);
  import tmfr_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES);

  logic [CNT_W-1:0]                  cnt_r;
  logic [CNT_W-1:0]                  cnt_eff;
  logic [CNT_W-1:0]                  cnt_nxt;
  row_t                              row_r;
  row_t                              row_cur;
  row_t                              row_nxt;
  logic                              first;
  logic                              last;
  logic                              fire;
  logic                              row_end;

  logic [CHANNELS-1:0][SUM_W-1:0]    sum_r;
  logic [CHANNELS-1:0][SUM_W-1:0]    sum_nxt;
  sample_vec_t                       min_r;
  sample_vec_t                       min_nxt;
  sample_vec_t                       max_r;
  sample_vec_t                       max_nxt;

  logic                              rec_valid_r;
  row_tag_t                          rec_tag_r;
  logic [CHANNELS-1:0][SUM_W-1:0]    rec_sum_r;
  sample_vec_t                       rec_min_r;
  sample_vec_t                       rec_max_r;

  // restart behaves as if the counters were already cleared
  assign cnt_eff = in_restart ? '0 : cnt_r;
  assign row_cur = in_restart ? '0 : row_r;
  assign first   = (cnt_eff == '0);
  assign last    = (cnt_eff == CNT_W'(SAMPLES - 1));
  assign row_end = (row_cur == ROW_BITS'(ROWS - 1));

  // only a row-completing beat needs room in the record register
  assign in_ready = !last || !rec_valid_r || rec_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (first) begin
        sum_nxt[c] = SUM_W'(in_samples[c]);
        min_nxt[c] = in_samples[c];
        max_nxt[c] = in_samples[c];
      end else begin
        sum_nxt[c] = sum_r[c] + SUM_W'(in_samples[c]);
        min_nxt[c] = (in_samples[c] < min_r[c]) ? in_samples[c] : min_r[c];
        max_nxt[c] = (in_samples[c] > max_r[c]) ? in_samples[c] : max_r[c];
      end
    end
  end

  always_comb begin
    if (last) begin
      cnt_nxt = '0;
      row_nxt = row_end ? '0 : row_cur + 1'b1;
    end else begin
      cnt_nxt = cnt_eff + 1'b1;
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      row_r       <= '0;
      rec_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        cnt_r <= cnt_nxt;
        row_r <= row_nxt;
      end
      if (fire && last) begin
        rec_valid_r <= 1'b1;
      end else if (rec_ready) begin
        rec_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sum_r <= sum_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
    if (fire && last) begin
      rec_tag_r.row  <= row_cur;
      rec_tag_r.done <= row_end;
      rec_sum_r      <= sum_nxt;
      rec_min_r      <= min_nxt;
      rec_max_r      <= max_nxt;
    end
  end

  assign rec_valid = rec_valid_r;
  assign rec_tag   = rec_tag_r;
  assign rec_sum   = rec_sum_r;
  assign rec_min   = rec_min_r;
  assign rec_max   = rec_max_r;

endmodule

// ----- src/tmfr_trim_div.sv -----
// ----------------------------------------------------------------------------
// tmfr_trim_div
// Two-stage trimmed mean: drop min and max from the sum, then divide by
// SAMPLES-2 through a multiply by a rounded-up reciprocal, exact for every
// value of the kept sum.
// ----------------------------------------------------------------------------
module tmfr_trim_div #(
  parameter int SAMPLES = 8,
  parameter int SUM_W   = 15
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  tmfr_pkg::row_tag_t                         in_tag,
  input  logic [tmfr_pkg::CHANNELS-1:0][SUM_W-1:0]   in_sum,
  input  tmfr_pkg::sample_vec_t                      in_min,
  input  tmfr_pkg::sample_vec_t                      in_max,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output tmfr_pkg::row_tag_t                         out_tag,
  output tmfr_pkg::sample_vec_t                      out_avg
);
  import tmfr_pkg::*;

  localparam int              DIV    = (SAMPLES > 2) ? SAMPLES - 2 : 1;
  localparam int              DIV_LD = $clog2(DIV);
  localparam int              SHIFT  = SUM_W + DIV_LD;
  localparam int              MULT_W = SUM_W + 1;
  localparam int              PROD_W = SUM_W + MULT_W;
  localparam longint unsigned MULT_L =
    ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_L);

  logic                                k_valid_r;
  logic                                k_en;
  row_tag_t                            k_tag_r;
  logic [CHANNELS-1:0][SUM_W-1:0]      kept_r;
  logic [CHANNELS-1:0][SUM_W-1:0]      kept_nxt;

  logic                                p_valid_r;
  logic                                p_en;
  row_tag_t                            p_tag_r;
  logic [CHANNELS-1:0][PROD_W-1:0]     prod_r;
  logic [CHANNELS-1:0][PROD_W-1:0]     prod_nxt;

  assign p_en     = !p_valid_r || out_ready;
  assign k_en     = !k_valid_r || p_en;
  assign in_ready = k_en;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      kept_nxt[c] = in_sum[c] - SUM_W'(in_min[c]) - SUM_W'(in_max[c]);
      prod_nxt[c] = PROD_W'(kept_r[c]) * PROD_W'(MULT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
    end else begin
      if (k_en) begin
        k_valid_r <= in_valid;
      end
      if (p_en) begin
        p_valid_r <= k_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (k_en && in_valid) begin
      k_tag_r <= in_tag;
      kept_r  <= kept_nxt;
    end
    if (p_en && k_valid_r) begin
      p_tag_r <= k_tag_r;
      prod_r  <= prod_nxt;
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      out_avg[c] = prod_r[c][SHIFT +: SAMPLE_BITS];
    end
  end

  assign out_valid = p_valid_r;
  assign out_tag   = p_tag_r;

endmodule

// ----- src/trimmed_mean_force_row_scanner.sv -----
// ----------------------------------------------------------------------------
// trimmed_mean_force_row_scanner
// Olympic average of six force channels per row: sum, drop min and max,
// divide by SAMPLES-2, then step to the next row.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one ADC conversion per beat (six samples and a restart
//   flag); a beat with restart high clears the accumulators and row counter
//   and counts as the first sample of row 0.
//   out_ch carries one beat per completed row: row index, scan-done flag on
//   row ROWS-1, and six trimmed means.
//   Throughput: one conversion per cycle, sustained while out_ch takes its
//   results; one result per SAMPLES conversions.
//   The beat that completes a row is captured in the input register and
//   passes the accumulators, trim subtract, reciprocal multiply and output
//   register before the result of the row is valid.
//   Reset clears all valid flags, the sample counter and the row counter.
//   While out_ch is stalled, conversions that do not complete a row are still
//   taken; the pipeline behind the output holds up to three further rows
//   before in_ch.ready drops.
// ----------------------------------------------------------------------------
module trimmed_mean_force_row_scanner #(
  parameter int SAMPLES = 8,
  parameter int ROWS    = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  tmfr_in_if.sink    in_ch,
  tmfr_out_if.source out_ch
);
  import tmfr_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLES);

  logic                              a_valid_r;
  logic                              a_restart_r;
  sample_vec_t                       a_samples_r;
  sample_vec_t                       in_samples;
  logic                              in_fire;

  logic                              acc_ready;
  logic                              rec_valid;
  logic                              rec_ready;
  row_tag_t                          rec_tag;
  logic [CHANNELS-1:0][SUM_W-1:0]    rec_sum;
  sample_vec_t                       rec_min;
  sample_vec_t                       rec_max;

  logic                              div_valid;
  row_tag_t                          div_tag;
  sample_vec_t                       div_avg;

  logic                              out_valid_r;
  logic                              out_en;
  row_tag_t                          out_tag_r;
  sample_vec_t                       out_avg_r;

  assign in_samples[0] = in_ch.sample_ch0;
  assign in_samples[1] = in_ch.sample_ch1;
  assign in_samples[2] = in_ch.sample_ch2;
  assign in_samples[3] = in_ch.sample_ch3;
  assign in_samples[4] = in_ch.sample_ch4;
  assign in_samples[5] = in_ch.sample_ch5;

  assign in_ch.ready = !a_valid_r || acc_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (acc_ready) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_restart_r <= in_ch.restart;
      a_samples_r <= in_samples;
    end
  end

  tmfr_accum #(
    .SAMPLES (SAMPLES),
    .ROWS    (ROWS),
    .SUM_W   (SUM_W)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (a_valid_r),
    .in_ready   (acc_ready),
    .in_restart (a_restart_r),
    .in_samples (a_samples_r),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec_tag    (rec_tag),
    .rec_sum    (rec_sum),
    .rec_min    (rec_min),
    .rec_max    (rec_max)
  );

  tmfr_trim_div #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W)
  ) u_trim_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rec_valid),
    .in_ready  (rec_ready),
    .in_tag    (rec_tag),
    .in_sum    (rec_sum),
    .in_min    (rec_min),
    .in_max    (rec_max),
    .out_valid (div_valid),
    .out_ready (out_en),
    .out_tag   (div_tag),
    .out_avg   (div_avg)
  );

  // output register: refill whenever empty or being drained
  assign out_en = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && div_valid) begin
      out_tag_r <= div_tag;
      out_avg_r <= div_avg;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_index = out_tag_r.row;
  assign out_ch.scan_done = out_tag_r.done;
  assign out_ch.avg_ch0   = out_avg_r[0];
  assign out_ch.avg_ch1   = out_avg_r[1];
  assign out_ch.avg_ch2   = out_avg_r[2];
  assign out_ch.avg_ch3   = out_avg_r[3];
  assign out_ch.avg_ch4   = out_avg_r[4];
  assign out_ch.avg_ch5   = out_avg_r[5];

endmodule

// ----- sim/tb_trimmed_mean_force_row_scanner.sv -----
// ----------------------------------------------------------------------------
// tb_trimmed_mean_force_row_scanner
// Self-checking bench for the trimmed-mean force row scanner. Conversions are
// pushed through the input channel and every accepted beat feeds a row
// predictor, which tracks sum, minimum and maximum per channel and queues the
// olympic average of each finished row. Result beats are compared field by
// field against the oldest queued row. A directed opening covers full-scale,
// zero, bit walks, seeding from the first sample and a restart in mid row;
// random rows with rare restarts follow, with random gaps on both sides, a
// long output hold-off that backs the block up, and a full drain pause.
// ----------------------------------------------------------------------------
module tb_trimmed_mean_force_row_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import tmfr_pkg::*;

  localparam int SAMPLES      = 8;
  localparam int ROWS         = 10;
  localparam int RANDOM_BEATS = 850;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    row_t        row;
    logic        done;
    sample_vec_t avg;
  } row_result_t;

  class row_scoreboard;
    localparam int TRIM_DIV = (SAMPLES > 2) ? SAMPLES - 2 : 1;

    logic [15:0] ch_sum [CHANNELS];
    sample_t     ch_min [CHANNELS];
    sample_t     ch_max [CHANNELS];
    int          taken;
    int          cur_row;
    row_result_t rows_due[$];
    int          errors;

    function new();
      taken   = 0;
      cur_row = 0;
      errors  = 0;
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // Fold one accepted conversion into the running row; queue the row average
    // once the last conversion of the row has been taken.
    function void note_conversion(logic restart, sample_vec_t s);
      row_result_t r;
      logic [15:0] kept;
      if (restart) begin
        taken   = 0;
        cur_row = 0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        if (taken == 0) begin
          ch_sum[c] = 16'(s[c]);
          ch_min[c] = s[c];
          ch_max[c] = s[c];
        end else begin
          ch_sum[c] = ch_sum[c] + 16'(s[c]);
          if (s[c] < ch_min[c]) ch_min[c] = s[c];
          if (s[c] > ch_max[c]) ch_max[c] = s[c];
        end
      end
      taken++;
      if (taken == SAMPLES) begin
        r.row  = row_t'(cur_row);
        r.done = (cur_row == ROWS - 1);
        for (int c = 0; c < CHANNELS; c++) begin
          kept     = ch_sum[c] - 16'(ch_min[c]) - 16'(ch_max[c]);
          r.avg[c] = sample_t'(kept / 16'(TRIM_DIV));
        end
        rows_due.push_back(r);
        taken   = 0;
        cur_row = (cur_row + 1 >= ROWS) ? 0 : cur_row + 1;
      end
    endfunction

    task check_result(row_t row, logic done, sample_vec_t avg);
      row_result_t want;
      if (rows_due.size() == 0) begin
        report($sformatf("unexpected result row %0d", row));
        return;
      end
      want = rows_due.pop_front();
      if (row !== want.row)
        report($sformatf("row_index got %0d expected %0d", row, want.row));
      if (done !== want.done)
        report($sformatf("scan_done row %0d got %0b expected %0b", want.row, done, want.done));
      for (int c = 0; c < CHANNELS; c++)
        if (avg[c] !== want.avg[c])
          report($sformatf("avg_ch%0d row %0d got %0d expected %0d",
                           c, want.row, avg[c], want.avg[c]));
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;

  tmfr_in_if  in_if ();
  tmfr_out_if out_if ();

  trimmed_mean_force_row_scanner #(
    .SAMPLES (SAMPLES),
    .ROWS    (ROWS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  row_scoreboard sb = new();

  int idle_cycles   = 0;
  int long_hold_req = 0;
  bit burst_mode    = 1'b0;
  bit fill_mode     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return sample_t'($urandom_range(0, 15));
      3:       return sample_t'(4095 - $urandom_range(0, 15));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Call at a falling edge; returns at a falling edge after the beat and gap.
  task automatic send_beat(input logic restart, input sample_vec_t s, input int gap);
    in_if.valid      <= 1'b1;
    in_if.restart    <= restart;
    in_if.sample_ch0 <= s[0];
    in_if.sample_ch1 <= s[1];
    in_if.sample_ch2 <= s[2];
    in_if.sample_ch3 <= s[3];
    in_if.sample_ch4 <= s[4];
    in_if.sample_ch5 <= s[5];
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off the input until every queued row has come out.
  task automatic wait_rows_drained();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic directed_rows();
    sample_vec_t s;
    // extremes, alternating full scale, walking ones, first sample as max/min
    for (int k = 0; k < SAMPLES; k++) begin
      s[0] = '0;
      s[1] = '1;
      s[2] = k[0] ? '1 : '0;
      s[3] = sample_t'(1) << k;
      s[4] = sample_t'(4095 - 3 * k);
      s[5] = sample_t'(10 + k);
      send_beat(k == 0, s, pick_gap());
    end
    // equal samples, upper walking ones, extremes late in the row
    for (int k = 0; k < SAMPLES; k++) begin
      s[0] = 12'd2048;
      s[1] = sample_t'(k);
      s[2] = k[0] ? 12'h555 : 12'hAAA;
      s[3] = sample_t'(1) << (k + 4);
      s[4] = (k == 3) ? '1 : 12'd100;
      s[5] = (k == SAMPLES - 1) ? '0 : 12'd500;
      send_beat(1'b0, s, pick_gap());
    end
    // abandon a partial row with a restart
    for (int k = 0; k < SAMPLES + 2; k++) begin
      for (int c = 0; c < CHANNELS; c++) s[c] = rand_sample();
      send_beat(k == 2, s, pick_gap());
    end
  endtask

  task automatic random_rows();
    sample_vec_t s;
    int          gap;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 100) burst_mode = 1'b1;
      if (i == 180) burst_mode = 1'b0;
      if (i == 300) begin
        fill_mode     = 1'b1;
        long_hold_req = LONG_HOLD;
      end
      if (i == 380) fill_mode = 1'b0;
      if (i == 600) wait_rows_drained();
      for (int c = 0; c < CHANNELS; c++) s[c] = rand_sample();
      gap = (burst_mode || fill_mode) ? 0 : pick_gap();
      send_beat($urandom_range(0, 199) == 0, s, gap);
    end
    in_if.valid <= 1'b0;
  endtask

  // Result side ready pattern, with one long hold-off on request.
  initial begin
    int stall_left;
    int hold;
    stall_left = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req > 0) begin
        hold          = long_hold_req;
        long_hold_req = 0;
        out_if.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (!burst_mode) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_conversion(in_if.restart,
                           {in_if.sample_ch5, in_if.sample_ch4, in_if.sample_ch3,
                            in_if.sample_ch2, in_if.sample_ch1, in_if.sample_ch0});
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.row_index, out_if.scan_done,
                        {out_if.avg_ch5, out_if.avg_ch4, out_if.avg_ch3,
                         out_if.avg_ch2, out_if.avg_ch1, out_if.avg_ch0});
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("trimmed_mean_force_row_scanner verification failed");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid      <= 1'b0;
    in_if.restart    <= 1'b0;
    in_if.sample_ch0 <= '0;
    in_if.sample_ch1 <= '0;
    in_if.sample_ch2 <= '0;
    in_if.sample_ch3 <= '0;
    in_if.sample_ch4 <= '0;
    in_if.sample_ch5 <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed_rows();
    random_rows();
    wait_rows_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d rows never reported", sb.pending()));
    if (sb.errors == 0) begin
      $display("trimmed_mean_force_row_scanner verification clean");
    end else begin
      $display("trimmed_mean_force_row_scanner verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tmfr_pkg.sv
src/tmfr_in_if.sv
src/tmfr_out_if.sv
src/tmfr_accum.sv
src/tmfr_trim_div.sv
src/trimmed_mean_force_row_scanner.sv
sim/tb_trimmed_mean_force_row_scanner.sv
